[hw/rtl/keyed_record_store_core_macros.svh]
// keyed_record_store_core_macros.svh: assertion macros for the record store checker
// depends on clk and arst_n being visible where a macro is used
`ifndef KEYED_RECORD_STORE_CORE_MACROS_SVH
`define KEYED_RECORD_STORE_CORE_MACROS_SVH

// same-cycle implication
`define KRS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed record store check failed");

// next-cycle implication
`define KRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed record store check failed");

`endif

[hw/rtl/krs_pkg.sv]
// krs_pkg: shared types, codes and helpers of the keyed record store
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package krs_pkg;

	localparam int STORE_BYTES_DEF = 1024;
	localparam int MAX_KEY_DEF     = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [10:0] CAP_RESET = 11'd1024;

	localparam logic [2:0] OP_SET    = 3'd0;
	localparam logic [2:0] OP_GET    = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_CLEAR  = 3'd3;
	localparam logic [2:0] OP_COUNT  = 3'd4;
	localparam logic [2:0] OP_KEYAT  = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_KEYLONG  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_SMALL    = 3'd5;

	localparam logic [1:0] K_CMD  = 2'd0;
	localparam logic [1:0] K_HDR  = 2'd1;
	localparam logic [1:0] K_WORD = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  opcode;
		logic [7:0]  key_length;
		logic [7:0]  value_length;
		logic [7:0]  read_capacity;
		logic [9:0]  record_index;
		logic [63:0] word;
		logic        fin;
		logic        abort;
	} entry_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  len;
		logic [9:0]  cnt;
		logic [63:0] word;
		logic        last;
	} res_t;

	function automatic logic [5:0] words_of(input logic [7:0] n);
		logic [8:0] s;
		s = {1'b0, n} + 9'd7;
		return s[8:3];
	endfunction

	function automatic res_t make_res(input logic [2:0] st, input logic [7:0] len,
			input logic [9:0] cnt, input logic [63:0] word, input logic last);
		res_t r;
		r.status = st;
		r.len    = len;
		r.cnt    = cnt;
		r.word   = word;
		r.last   = last;
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/krs_front.sv]
// krs_front: accepts input items and classifies them into queue entries
// depends on krs_pkg
`timescale 1ns / 1ps
`default_nettype none

module krs_front import krs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  key_length,
	input  logic [7:0]  value_length,
	input  logic [7:0]  read_capacity,
	input  logic [9:0]  record_index,
	input  logic [63:0] data_word,
	input  logic        last_item,
	input  logic        q_full,
	output logic        push,
	output entry_t      push_entry
);

	logic       busy_q;
	logic [6:0] need_q;
	logic [6:0] wseen_q;
	logic [6:0] need;
	logic       fin;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		need = 7'd0;
		if (opcode == OP_SET)
			need = {1'b0, words_of(key_length)} + {1'b0, words_of(value_length)};
		else if (opcode == OP_GET || opcode == OP_REMOVE)
			need = {1'b0, words_of(key_length)};
	end

	assign fin = (wseen_q + 7'd1) >= need_q;

	always_comb begin
		push_entry.opcode        = opcode;
		push_entry.key_length    = key_length;
		push_entry.value_length  = value_length;
		push_entry.read_capacity = read_capacity;
		push_entry.record_index  = record_index;
		push_entry.word          = data_word;
		push_entry.fin           = busy_q && fin;
		push_entry.abort         = busy_q && !fin && last_item;
		if (busy_q)
			push_entry.kind = K_WORD;
		else if (need == 7'd0)
			push_entry.kind = K_CMD;
		else
			push_entry.kind = K_HDR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			need_q  <= 7'd0;
			wseen_q <= 7'd0;
		end else if (push) begin
			if (!busy_q) begin
				if (need != 7'd0) begin
					busy_q  <= 1'b1;
					need_q  <= need;
					wseen_q <= 7'd0;
				end
			end else if (fin || last_item) begin
				busy_q  <= 1'b0;
				wseen_q <= 7'd0;
			end else begin
				wseen_q <= wseen_q + 7'd1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/krs_queue.sv]
// krs_queue: short transaction queue between front and back
// depends on krs_pkg
`timescale 1ns / 1ps
`default_nettype none

module krs_queue import krs_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   empty
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	entry_t          slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = count_q == CNTW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNTW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNTW'(1);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/krs_back.sv]
// krs_back: command sequencer over the record memory, hold buffers and result register
// depends on krs_pkg
`timescale 1ns / 1ps
`default_nettype none

module krs_back import krs_pkg::*; #(
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	parameter int MAX_KEY     = MAX_KEY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  logic        q_empty,
	output logic        pop,
	input  logic        cfg_write_en,
	input  logic [10:0] cfg_write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  reported_length,
	output logic [9:0]  record_count,
	output logic [63:0] out_word,
	output logic        last_result
);

	localparam int AW  = $clog2(STORE_BYTES);
	localparam int UW  = $clog2(STORE_BYTES + 1);
	localparam int XW  = ((UW > 10) ? UW : 10) + 1;
	localparam int CW  = (UW > 11) ? UW : 11;
	localparam int KB  = ((MAX_KEY + 7) / 8) * 8;
	localparam int KIB = $clog2(KB);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_WCHK   = 5'd2;
	localparam logic [4:0] S_WRK    = 5'd3;
	localparam logic [4:0] S_WRV    = 5'd4;
	localparam logic [4:0] S_LCHK   = 5'd5;
	localparam logic [4:0] S_LRK    = 5'd6;
	localparam logic [4:0] S_LRV    = 5'd7;
	localparam logic [4:0] S_LKB    = 5'd8;
	localparam logic [4:0] S_FOUND  = 5'd9;
	localparam logic [4:0] S_SETCHK = 5'd10;
	localparam logic [4:0] S_MVRD   = 5'd11;
	localparam logic [4:0] S_MVWR   = 5'd12;
	localparam logic [4:0] S_WHDR0  = 5'd13;
	localparam logic [4:0] S_WHDR1  = 5'd14;
	localparam logic [4:0] S_WKEY   = 5'd15;
	localparam logic [4:0] S_WVRD   = 5'd16;
	localparam logic [4:0] S_WVWR   = 5'd17;
	localparam logic [4:0] S_ERD    = 5'd18;
	localparam logic [4:0] S_EACC   = 5'd19;
	localparam logic [4:0] S_EOUT   = 5'd20;
	localparam logic [4:0] S_SEND   = 5'd21;

	logic [7:0]    record_bytes_q [STORE_BYTES];
	logic [63:0]   value_hold_q [32];
	logic [7:0]    key_hold_q [KB];
	logic [7:0]    rd_data_q;
	logic [63:0]   vh_rd_q;

	logic [4:0]    state_q;
	logic [4:0]    ret_q;
	logic [2:0]    op_q;
	logic [7:0]    k_q;
	logic [7:0]    v_q;
	logic [7:0]    rc_q;
	logic [9:0]    idx_q;
	logic [6:0]    wseen_q;
	logic [10:0]   cap_q;
	logic [UW-1:0] used_q;
	logic [UW-1:0] free_q;
	logic [UW-1:0] at_q;
	logic [UW-1:0] seen_q;
	logic [UW-1:0] offset_q;
	logic [UW-1:0] tail_q;
	logic [UW-1:0] src_q;
	logic [UW-1:0] dst_q;
	logic [UW-1:0] mvcnt_q;
	logic [UW-1:0] from_q;
	logic          mvup_q;
	logic          found_q;
	logic [7:0]    rk_q;
	logic [7:0]    rv_q;
	logic [9:0]    existing_q;
	logic [9:0]    wanted_q;
	logic [8:0]    i_q;
	logic [7:0]    len_q;
	logic [63:0]   word_buf_q;
	res_t          pend_q;
	res_t          out_q;
	logic          out_valid_q;

	logic          out_free;
	logic [5:0]    kw;
	logic          key_word;
	logic [7:0]    kh_byte;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [AW-1:0] mem_ra;
	logic [7:0]    mem_wd;
	logic          vh_we;
	logic [4:0]    vh_wa;
	logic [4:0]    vh_ra;
	logic          kh_we;
	logic [UW-1:0] at_p1;
	logic [UW-1:0] at_p2;
	logic [UW-1:0] at_kb;
	logic [UW-1:0] at_skip;
	logic [UW-1:0] a_hdr1;
	logic [UW-1:0] a_key;
	logic [UW-1:0] a_val;
	logic [UW-1:0] a_emit;
	logic [UW-1:0] used_new;
	logic [CW-1:0] cap_eff;
	logic [UW-1:0] free_c;
	logic [9:0]    cnt_sat;
	logic [9:0]    grow_by;

	assign out_free = !out_valid_q || !out_stall;
	assign kw       = words_of(k_q);
	assign key_word = wseen_q < {1'b0, kw};
	assign vh_wa    = 5'(wseen_q - {1'b0, kw});
	assign kh_byte  = key_hold_q[i_q[KIB-1:0]];

	assign at_p1    = at_q + UW'(1);
	assign at_p2    = at_q + UW'(2);
	assign at_kb    = at_q + UW'(3) + UW'(i_q);
	assign at_skip  = at_p2 + UW'(rk_q) + UW'((state_q == S_LKB) ? rv_q : rd_data_q);
	assign a_hdr1   = offset_q + UW'(1);
	assign a_key    = offset_q + UW'(2) + UW'(i_q);
	assign a_val    = offset_q + UW'(2) + UW'(k_q) + UW'(i_q);
	assign a_emit   = from_q + UW'(i_q);
	assign used_new = used_q - UW'(existing_q) + UW'(wanted_q);
	assign grow_by  = wanted_q - existing_q;

	assign cap_eff  = (CW'(cap_q) > CW'(STORE_BYTES)) ? CW'(STORE_BYTES) : CW'(cap_q);
	assign free_c   = (cap_eff > CW'(used_q)) ? UW'(cap_eff - CW'(used_q)) : '0;
	assign cnt_sat  = (XW'(seen_q) > XW'(1023)) ? 10'd1023 : 10'(seen_q);

	always_comb begin
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		vh_ra  = '0;
		vh_we  = 1'b0;
		kh_we  = 1'b0;
		pop    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				pop = !q_empty;
				if (!q_empty && head.kind == K_WORD) begin
					kh_we = key_word;
					vh_we = !key_word;
				end
			end
			S_WCHK, S_LCHK: mem_ra = at_q[AW-1:0];
			S_WRK, S_LRK: mem_ra = at_p1[AW-1:0];
			S_LRV: mem_ra = at_p2[AW-1:0];
			S_LKB: mem_ra = at_kb[AW-1:0];
			S_MVRD: mem_ra = src_q[AW-1:0];
			S_MVWR: begin
				mem_we = 1'b1;
				mem_wa = dst_q[AW-1:0];
				mem_wd = rd_data_q;
			end
			S_WHDR0: begin
				mem_we = 1'b1;
				mem_wa = offset_q[AW-1:0];
				mem_wd = k_q;
			end
			S_WHDR1: begin
				mem_we = 1'b1;
				mem_wa = a_hdr1[AW-1:0];
				mem_wd = v_q;
			end
			S_WKEY: begin
				mem_we = i_q != {1'b0, k_q};
				mem_wa = a_key[AW-1:0];
				mem_wd = kh_byte;
			end
			S_WVRD: vh_ra = i_q[7:3];
			S_WVWR: begin
				mem_we = 1'b1;
				mem_wa = a_val[AW-1:0];
				mem_wd = vh_rd_q[{i_q[2:0], 3'b000} +: 8];
			end
			S_ERD: mem_ra = a_emit[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			record_bytes_q[mem_wa] <= mem_wd;
		rd_data_q <= record_bytes_q[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (vh_we)
			value_hold_q[vh_wa] <= head.word;
		vh_rd_q <= value_hold_q[vh_ra];
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < KB; j++) begin
			if (kh_we && 7'(j / 8) == wseen_q)
				key_hold_q[j] <= head.word[8 * (j % 8) +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_write_en) begin
			cap_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			used_q  <= '0;
			wseen_q <= 7'd0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						unique case (head.kind)
							K_CMD, K_HDR: begin
								op_q    <= head.opcode;
								k_q     <= head.key_length;
								v_q     <= head.value_length;
								rc_q    <= head.read_capacity;
								idx_q   <= head.record_index;
								wseen_q <= 7'd0;
								if (head.kind == K_CMD)
									state_q <= S_DISP;
							end
							K_WORD: begin
								wseen_q <= wseen_q + 7'd1;
								if (head.fin) begin
									state_q <= S_DISP;
								end else if (head.abort) begin
									pend_q  <= make_res(ST_INVALID, 8'd0, 10'd0, 64'd0, 1'b1);
									ret_q   <= S_IDLE;
									state_q <= S_SEND;
								end
							end
							default: ;
						endcase
					end
				end
				S_DISP: begin
					free_q <= free_c;
					at_q   <= '0;
					seen_q <= '0;
					ret_q  <= S_IDLE;
					unique case (op_q) inside
						OP_CLEAR: begin
							used_q  <= '0;
							pend_q  <= make_res(ST_OK, 8'd0, 10'd0, 64'd0, 1'b1);
							state_q <= S_SEND;
						end
						OP_COUNT, OP_KEYAT: state_q <= S_WCHK;
						OP_SET, OP_GET, OP_REMOVE: begin
							if (k_q == 8'd0) begin
								pend_q  <= make_res(ST_INVALID, 8'd0, 10'd0, 64'd0, 1'b1);
								state_q <= S_SEND;
							end else if (k_q > 8'(MAX_KEY)) begin
								pend_q  <= make_res(ST_KEYLONG, 8'd0, 10'd0, 64'd0, 1'b1);
								state_q <= S_SEND;
							end else begin
								state_q <= S_LCHK;
							end
						end
						default: begin
							pend_q  <= make_res(ST_INVALID, 8'd0, 10'd0, 64'd0, 1'b1);
							state_q <= S_SEND;
						end
					endcase
				end
				S_WCHK: begin
					if (at_q < used_q) begin
						state_q <= S_WRK;
					end else begin
						if (op_q == OP_KEYAT)
							pend_q <= make_res(ST_NOTFOUND, 8'd0, 10'd0, 64'd0, 1'b1);
						else
							pend_q <= make_res(ST_OK, 8'd0, cnt_sat, 64'd0, 1'b1);
						ret_q   <= S_IDLE;
						state_q <= S_SEND;
					end
				end
				S_WRK: begin
					rk_q    <= rd_data_q;
					state_q <= S_WRV;
				end
				S_WRV: begin
					rv_q <= rd_data_q;
					if (op_q == OP_KEYAT && XW'(seen_q) == XW'(idx_q)) begin
						if (rk_q > rc_q) begin
							pend_q <= make_res(ST_SMALL, rk_q, 10'd0, 64'd0, 1'b1);
							ret_q  <= S_IDLE;
						end else begin
							pend_q <= make_res(ST_OK, rk_q, 10'd0, 64'd0, rk_q == 8'd0);
							ret_q  <= (rk_q == 8'd0) ? S_IDLE : S_ERD;
						end
						from_q     <= at_p2;
						len_q      <= rk_q;
						i_q        <= 9'd0;
						word_buf_q <= 64'd0;
						state_q    <= S_SEND;
					end else begin
						at_q    <= at_skip;
						seen_q  <= seen_q + UW'(1);
						state_q <= S_WCHK;
					end
				end
				S_LCHK: begin
					if (at_q < used_q) begin
						state_q <= S_LRK;
					end else begin
						found_q  <= 1'b0;
						offset_q <= used_q;
						state_q  <= S_FOUND;
					end
				end
				S_LRK: begin
					rk_q    <= rd_data_q;
					state_q <= S_LRV;
				end
				S_LRV: begin
					rv_q <= rd_data_q;
					i_q  <= 9'd0;
					if (rk_q == k_q) begin
						state_q <= S_LKB;
					end else begin
						at_q    <= at_skip;
						state_q <= S_LCHK;
					end
				end
				S_LKB: begin
					if (rd_data_q != kh_byte) begin
						at_q    <= at_skip;
						state_q <= S_LCHK;
					end else if (i_q + 9'd1 == {1'b0, k_q}) begin
						found_q  <= 1'b1;
						offset_q <= at_q;
						state_q  <= S_FOUND;
					end else begin
						i_q <= i_q + 9'd1;
					end
				end
				S_FOUND: begin
					existing_q <= 10'd2 + 10'(rk_q) + 10'(rv_q);
					wanted_q   <= 10'd2 + 10'(k_q) + 10'(v_q);
					tail_q     <= offset_q + UW'(2) + UW'(rk_q) + UW'(rv_q);
					ret_q      <= S_IDLE;
					unique case (op_q) inside
						OP_GET: begin
							state_q <= S_SEND;
							if (!found_q) begin
								pend_q <= make_res(ST_NOTFOUND, 8'd0, 10'd0, 64'd0, 1'b1);
							end else if (rv_q > rc_q) begin
								pend_q <= make_res(ST_SMALL, rv_q, 10'd0, 64'd0, 1'b1);
							end else begin
								pend_q     <= make_res(ST_OK, rv_q, 10'd0, 64'd0, rv_q == 8'd0);
								ret_q      <= (rv_q == 8'd0) ? S_IDLE : S_ERD;
								from_q     <= offset_q + UW'(2) + UW'(k_q);
								len_q      <= rv_q;
								i_q        <= 9'd0;
								word_buf_q <= 64'd0;
							end
						end
						OP_REMOVE: begin
							if (!found_q) begin
								pend_q  <= make_res(ST_NOTFOUND, 8'd0, 10'd0, 64'd0, 1'b1);
								state_q <= S_SEND;
							end else begin
								state_q <= S_SETCHK;
							end
						end
						OP_SET: state_q <= S_SETCHK;
						default: state_q <= S_IDLE;
					endcase
				end
				S_SETCHK: begin
					ret_q   <= S_IDLE;
					state_q <= S_MVRD;
					if (op_q == OP_REMOVE) begin
						src_q   <= tail_q;
						dst_q   <= offset_q;
						mvcnt_q <= used_q - tail_q;
						mvup_q  <= 1'b1;
						used_q  <= used_q - UW'(existing_q);
					end else if (found_q) begin
						if (wanted_q > existing_q && XW'(grow_by) > XW'(free_q)) begin
							pend_q  <= make_res(ST_FULL, 8'd0, 10'd0, 64'd0, 1'b1);
							state_q <= S_SEND;
						end else begin
							used_q  <= used_new;
							mvcnt_q <= used_q - tail_q;
							if (wanted_q > existing_q) begin
								mvup_q <= 1'b0;
								src_q  <= used_q - UW'(1);
								dst_q  <= used_new - UW'(1);
							end else begin
								mvup_q <= 1'b1;
								src_q  <= tail_q;
								dst_q  <= offset_q + UW'(wanted_q);
							end
						end
					end else begin
						if (XW'(wanted_q) > XW'(free_q)) begin
							pend_q  <= make_res(ST_FULL, 8'd0, 10'd0, 64'd0, 1'b1);
							state_q <= S_SEND;
						end else begin
							used_q  <= used_q + UW'(wanted_q);
							mvcnt_q <= '0;
						end
					end
				end
				S_MVRD: begin
					if (mvcnt_q == '0) begin
						if (op_q == OP_REMOVE) begin
							pend_q  <= make_res(ST_OK, 8'd0, 10'd0, 64'd0, 1'b1);
							ret_q   <= S_IDLE;
							state_q <= S_SEND;
						end else begin
							state_q <= S_WHDR0;
						end
					end else begin
						state_q <= S_MVWR;
					end
				end
				S_MVWR: begin
					mvcnt_q <= mvcnt_q - UW'(1);
					src_q   <= mvup_q ? src_q + UW'(1) : src_q - UW'(1);
					dst_q   <= mvup_q ? dst_q + UW'(1) : dst_q - UW'(1);
					state_q <= S_MVRD;
				end
				S_WHDR0: state_q <= S_WHDR1;
				S_WHDR1: begin
					i_q     <= 9'd0;
					state_q <= S_WKEY;
				end
				S_WKEY: begin
					if (i_q == {1'b0, k_q}) begin
						i_q     <= 9'd0;
						state_q <= S_WVRD;
					end else begin
						i_q <= i_q + 9'd1;
					end
				end
				S_WVRD: begin
					if (i_q == {1'b0, v_q}) begin
						pend_q  <= make_res(ST_OK, 8'd0, 10'd0, 64'd0, 1'b1);
						ret_q   <= S_IDLE;
						state_q <= S_SEND;
					end else begin
						state_q <= S_WVWR;
					end
				end
				S_WVWR: begin
					i_q     <= i_q + 9'd1;
					state_q <= S_WVRD;
				end
				S_ERD: state_q <= S_EACC;
				S_EACC: begin
					word_buf_q[{i_q[2:0], 3'b000} +: 8] <=
						(i_q < {1'b0, len_q}) ? rd_data_q : 8'd0;
					i_q     <= i_q + 9'd1;
					state_q <= (i_q[2:0] == 3'd7) ? S_EOUT : S_ERD;
				end
				S_EOUT: begin
					pend_q     <= make_res(ST_OK, len_q, 10'd0, word_buf_q,
						i_q >= {1'b0, len_q});
					ret_q      <= (i_q >= {1'b0, len_q}) ? S_IDLE : S_ERD;
					word_buf_q <= 64'd0;
					state_q    <= S_SEND;
				end
				S_SEND: begin
					if (out_free)
						state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_SEND && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SEND && out_free)
			out_q <= pend_q;
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign reported_length = out_q.len;
	assign record_count    = out_q.cnt;
	assign out_word        = out_q.word;
	assign last_result     = out_q.last;

endmodule

`default_nettype wire

[hw/rtl/keyed_record_store_core.sv]
// keyed record store: a command enters at one item per cycle while in_stall is low; execution
// is byte serial: records are walked, key bytes compared, bytes moved or written and result
// words gathered one byte at a time, between dispatch and result; the sequencer in krs_back
// over the record memory (one read port, one write port) sets the rate; items queue 4 deep meanwhile
// reset is asynchronous: record count and control clear at once, capacity reads 1024,
// record memory and hold buffers are undefined until written (no clearing pass)
`timescale 1ns / 1ps
`default_nettype none

module keyed_record_store_core import krs_pkg::*; #(
	parameter int STORE_BYTES = STORE_BYTES_DEF,
	parameter int MAX_KEY     = MAX_KEY_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [7:0]  key_length,
	input  logic [7:0]  value_length,
	input  logic [7:0]  read_capacity,
	input  logic [9:0]  record_index,
	input  logic [63:0] data_word,
	input  logic        last_item,
	input  logic        cfg_write_en,
	input  logic [10:0] cfg_write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  reported_length,
	output logic [9:0]  record_count,
	output logic [63:0] out_word,
	output logic        last_result
);

	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   pop;
	entry_t head;
	logic   q_empty;

	krs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.key_length    (key_length),
		.value_length  (value_length),
		.read_capacity (read_capacity),
		.record_index  (record_index),
		.data_word     (data_word),
		.last_item     (last_item),
		.q_full        (q_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	krs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty)
	);

	krs_back #(
		.STORE_BYTES (STORE_BYTES),
		.MAX_KEY     (MAX_KEY)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_empty         (q_empty),
		.pop             (pop),
		.cfg_write_en    (cfg_write_en),
		.cfg_write_data  (cfg_write_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.reported_length (reported_length),
		.record_count    (record_count),
		.out_word        (out_word),
		.last_result     (last_result)
	);

endmodule

`default_nettype wire

[hw/rtl/krs_checker.sv]
// krs_checker: port-level checks of the record store result stream, bound to the top level
// depends on krs_pkg and keyed_record_store_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_record_store_core_macros.svh"

module krs_checker import krs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [7:0]  reported_length,
	input logic [9:0]  record_count,
	input logic [63:0] out_word,
	input logic        last_result
);

	// a stalled transaction stays offered
	`KRS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
	// error results end their command
	`KRS_ASSERT_SAME(a_err_last, out_valid && status != ST_OK, last_result)
	// only ok results with a length can be followed by data
	`KRS_ASSERT_SAME(a_more_ok, out_valid && !last_result,
		status == ST_OK && reported_length != 8'd0)
	// a count answer is a lone status transaction
	`KRS_ASSERT_SAME(a_count, out_valid && record_count != 10'd0,
		status == ST_OK && last_result && out_word == 64'd0 && reported_length == 8'd0)

endmodule

bind keyed_record_store_core krs_checker u_krs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.status          (status),
	.reported_length (reported_length),
	.record_count    (record_count),
	.out_word        (out_word),
	.last_result     (last_result)
);

`default_nettype wire

[tb/sv/testbench.sv]
// testbench for keyed_record_store_core: directed table then random commands, each checked
// against a behavioral model of the packed record store in this file, typed rows against
// their own status, length and count; depends on krs_pkg for codes and the result struct
`timescale 1ns / 1ps

module testbench;
	import krs_pkg::*;

	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;
	localparam int LIMIT = 4000000;
	localparam int DRAIN = 3000;

	typedef struct {
		logic [2:0]  op;
		logic [7:0]  klen;
		logic [7:0]  vlen;
		logic [7:0]  rcap;
		logic [9:0]  idx;
		logic [63:0] word;
		logic        last;
		bit          typed;
		logic [2:0]  st;
		logic [7:0]  len;
		logic [9:0]  cnt;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [7:0]  key_length = '0;
	logic [7:0]  value_length = '0;
	logic [7:0]  read_capacity = '0;
	logic [9:0]  record_index = '0;
	logic [63:0] data_word = '0;
	logic        last_item = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [10:0] cfg_write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  reported_length;
	logic [9:0]  record_count;
	logic [63:0] out_word;
	logic        last_result;

	keyed_record_store_core uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .key_length(key_length), .value_length(value_length),
		.read_capacity(read_capacity), .record_index(record_index), .data_word(data_word),
		.last_item(last_item), .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.reported_length(reported_length), .record_count(record_count),
		.out_word(out_word), .last_result(last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// record store model
	logic [7:0]  store_mem [0:1023];
	int          store_used;
	logic [7:0]  key_buf [0:31];
	logic [7:0]  val_buf [0:255];
	logic [10:0] capacity;
	bit          cmd_open;
	logic [2:0]  hdr_op;
	logic [7:0]  hdr_k, hdr_v, hdr_rc;
	int          words_in;

	res_t expected_results[$];
	res_t fresh[$];
	int   errors = 0;
	int   items_sent = 0;
	int   cycles = 0;
	bit   quiet = 0;
	int   stall_left = 0;

	logic [7:0] pool_key [0:5][0:31];
	int         pool_len [0:5];
	stim_row_t  stim_rows[$];

	function automatic int word_count(int n);
		return (n + 7) / 8;
	endfunction

	function automatic int rd_byte(int i);
		return (i < 1024) ? int'(store_mem[i]) : 0;
	endfunction

	function automatic int payload_need(logic [2:0] op, int k, int v);
		if (op == OP_SET) return word_count(k) + word_count(v);
		if (op == OP_GET || op == OP_REMOVE) return word_count(k);
		return 0;
	endfunction

	function automatic int room_left();
		int c;
		c = (capacity > 1024) ? 1024 : int'(capacity);
		return (c > store_used) ? c - store_used : 0;
	endfunction

	function automatic void add_res(logic [2:0] st, int len, int cnt, logic [63:0] w, bit last);
		res_t r;
		r.status = st;
		r.len = len[7:0];
		r.cnt = cnt[9:0];
		r.word = w;
		r.last = last;
		fresh.push_back(r);
	endfunction

	function automatic bit find_key(int k, output int off);
		int at, rk, rv;
		bit same;
		at = 0;
		while (at < store_used) begin
			rk = rd_byte(at);
			rv = rd_byte(at + 1);
			same = (rk == k);
			for (int i = 0; same && i < k; i++)
				if (rd_byte(at + 2 + i) != int'(key_buf[i])) same = 0;
			if (same) begin
				off = at;
				return 1;
			end
			at += 2 + rk + rv;
		end
		off = store_used;
		return 0;
	endfunction

	function automatic void emit_span(int from, int len);
		int nw;
		logic [63:0] w;
		nw = word_count(len);
		add_res(ST_OK, len, 0, 64'd0, nw == 0);
		for (int j = 0; j < nw; j++) begin
			w = '0;
			for (int b = 0; b < 8; b++)
				if (j * 8 + b < len) w[8*b +: 8] = rd_byte(from + j * 8 + b);
			add_res(ST_OK, len, 0, w, j + 1 == nw);
		end
	endfunction

	function automatic void run_cmd(logic [2:0] op, int k, int v, int rc, int idx);
		int at, seen, rk, rv, off, wanted, existing, tail, sz, vl;
		logic [7:0] moved[$];
		if (op == OP_CLEAR) begin
			store_used = 0;
			add_res(ST_OK, 0, 0, 0, 1);
			return;
		end
		if (op == OP_COUNT || op == OP_KEYAT) begin
			at = 0;
			seen = 0;
			while (at < store_used) begin
				rk = rd_byte(at);
				rv = rd_byte(at + 1);
				if (op == OP_KEYAT && seen == idx) begin
					if (rk > rc) add_res(ST_SMALL, rk, 0, 0, 1);
					else emit_span(at + 2, rk);
					return;
				end
				at += 2 + rk + rv;
				seen++;
			end
			if (op == OP_KEYAT) add_res(ST_NOTFOUND, 0, 0, 0, 1);
			else add_res(ST_OK, 0, (seen > 1023) ? 1023 : seen, 0, 1);
			return;
		end
		if (op > OP_KEYAT || k == 0) begin
			add_res(ST_INVALID, 0, 0, 0, 1);
			return;
		end
		if (k > 32) begin
			add_res(ST_KEYLONG, 0, 0, 0, 1);
			return;
		end
		if (op == OP_SET) begin
			wanted = 2 + k + v;
			if (find_key(k, off)) begin
				existing = 2 + rd_byte(off) + rd_byte(off + 1);
				tail = off + existing;
				if (wanted > existing && wanted - existing > room_left()) begin
					add_res(ST_FULL, 0, 0, 0, 1);
					return;
				end
				for (int i = tail; i < store_used; i++) moved.push_back(store_mem[i]);
				foreach (moved[i])
					if (off + wanted + i < 1024) store_mem[off + wanted + i] = moved[i];
				store_used = store_used - existing + wanted;
			end else begin
				if (wanted > room_left()) begin
					add_res(ST_FULL, 0, 0, 0, 1);
					return;
				end
				store_used += wanted;
			end
			if (off < 1024) store_mem[off] = k;
			if (off + 1 < 1024) store_mem[off + 1] = v;
			for (int i = 0; i < k; i++)
				if (off + 2 + i < 1024) store_mem[off + 2 + i] = key_buf[i];
			for (int i = 0; i < v; i++)
				if (off + 2 + k + i < 1024) store_mem[off + 2 + k + i] = val_buf[i];
			add_res(ST_OK, 0, 0, 0, 1);
			return;
		end
		if (!find_key(k, off)) begin
			add_res(ST_NOTFOUND, 0, 0, 0, 1);
			return;
		end
		if (op == OP_REMOVE) begin
			sz = 2 + rd_byte(off) + rd_byte(off + 1);
			for (int i = off + sz; i < store_used; i++) store_mem[i - sz] = store_mem[i];
			store_used -= sz;
			add_res(ST_OK, 0, 0, 0, 1);
			return;
		end
		vl = rd_byte(off + 1);
		if (vl > rc) add_res(ST_SMALL, vl, 0, 0, 1);
		else emit_span(off + 2 + k, vl);
	endfunction

	// feeds one accepted transaction into the model, results land in fresh
	function automatic void model_take(stim_row_t r);
		int need, kw, bi;
		if (!cmd_open) begin
			need = payload_need(r.op, r.klen, r.vlen);
			if (need == 0) begin
				run_cmd(r.op, r.klen, r.vlen, r.rcap, r.idx);
				return;
			end
			cmd_open = 1;
			hdr_op = r.op;
			hdr_k = r.klen;
			hdr_v = r.vlen;
			hdr_rc = r.rcap;
			words_in = 0;
			return;
		end
		need = payload_need(hdr_op, hdr_k, hdr_v);
		kw = word_count(hdr_k);
		for (int b = 0; b < 8; b++) begin
			if (words_in < kw) begin
				bi = words_in * 8 + b;
				if (bi < hdr_k && bi < 32) key_buf[bi] = r.word[8*b +: 8];
			end else begin
				bi = (words_in - kw) * 8 + b;
				if (bi < hdr_v) val_buf[bi] = r.word[8*b +: 8];
			end
		end
		words_in++;
		if (words_in >= need) begin
			cmd_open = 0;
			run_cmd(hdr_op, hdr_k, hdr_v, hdr_rc, 0);
		end else if (r.last) begin
			cmd_open = 0;
			add_res(ST_INVALID, 0, 0, 0, 1);
		end
	endfunction

	task automatic send_item(stim_row_t r);
		res_t t;
		opcode <= r.op;
		key_length <= r.klen;
		value_length <= r.vlen;
		read_capacity <= r.rcap;
		record_index <= r.idx;
		data_word <= r.word;
		last_item <= r.last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
		fresh.delete();
		model_take(r);
		if (r.typed) begin
			t.status = r.st;
			t.len = r.len;
			t.cnt = r.cnt;
			t.word = '0;
			t.last = 1'b1;
			fresh.delete();
			fresh.push_back(t);
		end
		foreach (fresh[i]) expected_results.push_back(fresh[i]);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	function automatic stim_row_t mk(logic [2:0] op, int k, int v, int rc, int idx,
			logic [63:0] w, bit last);
		stim_row_t r;
		r.op = op;
		r.klen = k;
		r.vlen = v;
		r.rcap = rc;
		r.idx = idx;
		r.word = w;
		r.last = last;
		r.typed = 0;
		r.st = ST_OK;
		r.len = 0;
		r.cnt = 0;
		return r;
	endfunction

	function automatic stim_row_t mk_typed(stim_row_t r, logic [2:0] st, int len, int cnt);
		r.typed = 1;
		r.st = st;
		r.len = len;
		r.cnt = cnt;
		return r;
	endfunction

	task automatic set_capacity(logic [10:0] c);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_write_data <= c;
		cfg_write_en <= 1'b1;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		capacity = c;
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	// one random command, mostly well formed keys from a small pool
	task automatic random_command();
		int pick, k, v, rc, kind, nk, nv, stop_at;
		logic [2:0] op;
		logic [63:0] w;
		bit pool;
		kind = $urandom_range(0, 99);
		pick = $urandom_range(0, 5);
		pool = ($urandom_range(0, 9) != 0);
		k = pool ? pool_len[pick] : $urandom_range(1, 32);
		v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
		rc = ($urandom_range(0, 1) != 0) ? 255 : $urandom_range(0, 255);
		if (kind < 40) op = OP_SET;
		else if (kind < 60) op = OP_GET;
		else if (kind < 70) op = OP_REMOVE;
		else if (kind < 76) op = OP_COUNT;
		else if (kind < 84) op = OP_KEYAT;
		else if (kind < 86) op = OP_CLEAR;
		else if (kind < 88) op = ($urandom_range(0, 1) != 0) ? OP_BAD6 : OP_BAD7;
		else if (kind < 92) begin
			op = $urandom_range(0, 2);
			k = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(33, 255);
		end else op = $urandom_range(0, 2);
		send_item(mk(op, k, v, rc, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
			: $urandom_range(0, 8), rand_word(), $urandom_range(0, 1)));
		if (!cmd_open) return;
		nk = word_count(k);
		nv = (op == OP_SET) ? word_count(v) : 0;
		// a few commands are cut short
		stop_at = (kind >= 92) ? $urandom_range(1, nk + nv) : nk + nv;
		for (int j = 0; j < stop_at; j++) begin
			w = rand_word();
			if (pool && j < nk)
				for (int b = 0; b < 8; b++)
					if (j * 8 + b < k) w[8*b +: 8] = pool_key[pick][j * 8 + b];
			send_item(mk(OP_SET, 0, 0, 0, 0, w,
				(j == stop_at - 1) ? (stop_at < nk + nv || $urandom_range(0, 1)) : 1'b0));
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 16);
			out_stall <= 1'b1;
		end else out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result status %0d word %h", $time, status, out_word);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) begin
					$display("%0t status exp %0d got %0d", $time, e.status, status);
					errors++;
				end
				if (reported_length !== e.len) begin
					$display("%0t length exp %0d got %0d", $time, e.len, reported_length);
					errors++;
				end
				if (record_count !== e.cnt) begin
					$display("%0t count exp %0d got %0d", $time, e.cnt, record_count);
					errors++;
				end
				if (out_word !== e.word) begin
					$display("%0t word exp %h got %h", $time, e.word, out_word);
					errors++;
				end
				if (last_result !== e.last) begin
					$display("%0t last exp %0d got %0d", $time, e.last, last_result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [10:0] caps [0:5];
		foreach (store_mem[i]) store_mem[i] = '0;
		foreach (key_buf[i]) key_buf[i] = '0;
		foreach (val_buf[i]) val_buf[i] = '0;
		store_used = 0;
		capacity = CAP_RESET;
		cmd_open = 0;
		for (int p = 0; p < 6; p++) begin
			pool_len[p] = (p == 0) ? 1 : (p == 1) ? 32 : $urandom_range(2, 31);
			for (int b = 0; b < 32; b++) pool_key[p][b] = $urandom_range(0, 255);
		end

		stim_rows.push_back(mk_typed(mk(OP_COUNT, 0, 0, 0, 0, 0, 1), ST_OK, 0, 0));
		stim_rows.push_back(mk_typed(mk(OP_GET, 0, 0, 255, 0, 0, 0), ST_INVALID, 0, 0));
		stim_rows.push_back(mk_typed(mk(OP_BAD6, 5, 5, 5, 5, 0, 0), ST_INVALID, 0, 0));
		stim_rows.push_back(mk_typed(mk(OP_BAD7, 255, 255, 255, 1023, '1, 1), ST_INVALID, 0, 0));
		stim_rows.push_back(mk_typed(mk(OP_KEYAT, 1, 0, 255, 0, 0, 1), ST_NOTFOUND, 0, 0));
		// long key: header, five key words with last low throughout
		stim_rows.push_back(mk(OP_SET, 40, 0, 0, 0, 0, 0));
		for (int j = 0; j < 4; j++) stim_rows.push_back(mk(OP_SET, 0, 0, 0, 0, '1, 0));
		stim_rows.push_back(mk_typed(mk(OP_SET, 0, 0, 0, 0, '1, 0), ST_KEYLONG, 0, 0));
		// one byte key, eight byte value of all ones
		stim_rows.push_back(mk(OP_SET, 1, 8, 0, 0, 0, 0));
		stim_rows.push_back(mk(OP_SET, 0, 0, 0, 0, 64'h00000000000000A5, 0));
		stim_rows.push_back(mk(OP_SET, 0, 0, 0, 0, '1, 1));
		stim_rows.push_back(mk(OP_GET, 1, 0, 255, 0, 0, 0));
		stim_rows.push_back(mk(OP_SET, 0, 0, 0, 0, 64'h00000000000000A5, 1));
		stim_rows.push_back(mk(OP_GET, 1, 0, 0, 0, 0, 1));
		stim_rows.push_back(mk(OP_SET, 0, 0, 0, 0, 64'h00000000000000A5, 1));
		// early end: value word never comes
		stim_rows.push_back(mk(OP_SET, 8, 8, 0, 0, 0, 0));
		stim_rows.push_back(mk_typed(mk(OP_SET, 0, 0, 0, 0, 0, 1), ST_INVALID, 0, 0));
		stim_rows.push_back(mk(OP_KEYAT, 0, 0, 255, 0, 0, 1));
		stim_rows.push_back(mk(OP_KEYAT, 0, 0, 0, 0, 0, 1));
		stim_rows.push_back(mk(OP_REMOVE, 1, 0, 0, 0, 0, 0));
		stim_rows.push_back(mk(OP_SET, 0, 0, 0, 0, 64'h00000000000000A5, 1));
		stim_rows.push_back(mk_typed(mk(OP_COUNT, 0, 0, 0, 0, 0, 0), ST_OK, 0, 0));
		stim_rows.push_back(mk_typed(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), ST_OK, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim_rows[i]) send_item(stim_rows[i]);

		caps[0] = 11'd1024;
		caps[1] = 11'd120;
		caps[2] = 11'd2047;
		caps[3] = 11'd1;
		caps[4] = 11'd40;
		caps[5] = 11'd1000;
		for (int p = 0; p < 6; p++) begin
			set_capacity(caps[p]);
			if (p == 5) quiet = 1;
			while (items_sent < 25 + (p + 1) * 36) random_command();
		end

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
